@@ hdl/set_statistics_engine_top_macros.svh @@
// assertion macros for the set statistics engine
`ifndef SET_STATISTICS_ENGINE_TOP_MACROS_SVH
`define SET_STATISTICS_ENGINE_TOP_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define SES_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ses: same-cycle check failed");

// next-cycle implication
`define SES_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ses: next-cycle check failed");

`endif

@@ hdl/ses_pkg.sv @@
// shared types and constants of the set statistics engine
`default_nettype none
package ses_pkg;
	localparam int SAMPLE_W   = 24;
	localparam int MEAN_W     = 24;
	localparam int SD_W       = 23;
	localparam int PC_W       = 32;
	localparam int SETS_W     = 16;
	localparam int ENTRIES_W  = 11;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int PC_SCALE_W = 15;
	localparam int PC_MAG_W   = SAMPLE_W + 1 + PC_SCALE_W;
	localparam int SQRT_IN_W  = 64;
	localparam int SQRT_OUT_W = 32;

	localparam logic [PC_SCALE_W-1:0] PC_SCALE = 15'd25600;
	localparam logic [SD_W-1:0]       SD_MAX   = {SD_W{1'b1}};

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETS    = 1'b1;

	// divider operand selection
	localparam logic [1:0] DIV_MEAN = 2'd0;
	localparam logic [1:0] DIV_ESQ  = 2'd1;
	localparam logic [1:0] DIV_PC   = 2'd2;

	typedef struct packed {
		logic       acc;
		logic       prep;
		logic       div_start;
		logic [1:0] div_sel;
		logic       cap_mean;
		logic       cap_esq;
		logic       msq;
		logic       var_en;
		logic       sqrt_start;
		logic       cap_pc;
		logic       load_out;
	} ses_cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
		logic div_busy;
		logic sqrt_done;
		logic sqrt_busy;
		logic out_free;
		logic first_zero;
	} ses_stat_t;
endpackage
`default_nettype wire

@@ hdl/ses_div.sv @@
// shift-subtract divider, one quotient bit per cycle
`default_nettype none
module ses_div import ses_pkg::*; #(
	parameter int QW = 58,
	parameter int DW = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [QW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic               done,
	output logic [QW-1:0]      quotient
);
	localparam int CNT_W = $clog2(QW + 1);

	logic [QW-1:0]    dq_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      rem_sub;
	logic             ge;

	// trial subtract of the shifted remainder
	always_comb begin
		rem_sh  = {rem_q, dq_q[QW-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		ge      = rem_sh >= {1'b0, dvs_q};
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// dividend shifts out as quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			dq_q  <= {dq_q[QW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;
endmodule
`default_nettype wire

@@ hdl/ses_sqrt.sv @@
// digit-by-digit integer square root, one root bit per cycle
`default_nettype none
module ses_sqrt import ses_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [SQRT_IN_W-1:0]  radicand,
	output logic                       busy,
	output logic                       done,
	output logic [SQRT_OUT_W-1:0]      root
);
	localparam int RW    = SQRT_OUT_W + 2;
	localparam int CNT_W = $clog2(SQRT_OUT_W + 1);

	logic [SQRT_IN_W-1:0]  v_q;
	logic [RW-1:0]         rem_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [RW+1:0]         rem_sh;
	logic [RW+1:0]         trial;
	logic [RW+1:0]         rem_sub;
	logic                  ge;

	// bring down two bits and try the next root digit
	always_comb begin
		rem_sh  = {rem_q, v_q[SQRT_IN_W-1 -: 2]};
		trial   = {2'b00, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		ge      = rem_sh >= trial;
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(SQRT_OUT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// root and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[SQRT_IN_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
			root_q <= {root_q[SQRT_OUT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

@@ hdl/ses_dp.sv @@
// datapath: accumulators, back-end arithmetic and result register
`default_nettype none
module ses_dp import ses_pkg::*; #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic [SAMPLE_W-1:0]   sample,
	input  wire ses_cmd_t              cmd,
	output ses_stat_t                  stat,
	input  wire logic                  out_ready,
	output logic                       out_valid,
	output logic signed [MEAN_W-1:0]   mean_value,
	output logic [SD_W-1:0]            std_deviation,
	output logic signed [PC_W-1:0]     pct_change,
	output logic                       first_was_zero,
	output logic [SETS_W-1:0]          set_index,
	output logic                       last_set
);
	localparam int CW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int NW   = $clog2(MAX_ENTRIES + 1);
	localparam int SUMW = SAMPLE_W + CW;
	localparam int SQW  = 2 * SAMPLE_W + CW;
	localparam int MSQW = 2 * MEAN_W;
	localparam int DVW_A = (SUMW + 1 > SQW) ? SUMW + 1 : SQW;
	localparam int DVW   = (DVW_A > PC_MAG_W + 1) ? DVW_A : PC_MAG_W + 1;
	localparam int DSW   = (NW > SAMPLE_W) ? NW : SAMPLE_W;

	// configuration
	logic [ENTRIES_W-1:0] entries_q;
	logic [SETS_W-1:0]    sets_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_W'(8);
			sets_q    <= SETS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENTRIES: entries_q <= cfg_data[ENTRIES_W-1:0];
				CFG_SETS:    sets_q    <= cfg_data[SETS_W-1:0];
				default:     ;
			endcase
		end
	end

	// effective set length and close test
	logic [31:0]   entries_ext;
	logic [NW-1:0] len_eff;
	logic [CW-1:0] count_q;
	logic [NW-1:0] n_now;
	logic [NW-1:0] n_q;

	always_comb begin
		entries_ext = 32'(entries_q);
		if (entries_ext == 32'd0) begin
			len_eff = NW'(1);
		end else if (entries_ext > 32'(MAX_ENTRIES)) begin
			len_eff = NW'(MAX_ENTRIES);
		end else begin
			len_eff = entries_ext[NW-1:0];
		end
		n_now = NW'(count_q) + NW'(1);
	end

	// sample magnitude and its square
	logic [SAMPLE_W-1:0]        smag;
	logic signed [SAMPLE_W-1:0] first_q;
	logic signed [SAMPLE_W-1:0] last_q;
	logic signed [SUMW-1:0]     sum_q;
	logic [SQW-1:0]             sqsum_q;
	logic [2*SAMPLE_W-1:0]      sq_s1;
	logic                       sq_v_s1;

	assign smag = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;

	// square stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s1 <= 1'b0;
		end else begin
			sq_v_s1 <= cmd.acc;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			sq_s1 <= smag * smag;
		end
	end

	// accumulators, cleared once the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			first_q <= '0;
		end else if (cmd.load_out) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			first_q <= '0;
		end else begin
			if (cmd.acc) begin
				sum_q <= sum_q + {{(SUMW-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
				if (count_q == '0) begin
					first_q <= sample;
				end
				if (!stat.close) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (sq_v_s1) begin
				sqsum_q <= sqsum_q + SQW'(sq_s1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc) begin
			last_q <= sample;
			n_q    <= n_now;
		end
	end

	// percent change numerator magnitude and sign
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0]        dmag;
	logic [SAMPLE_W-1:0]      first_mag;
	logic [PC_MAG_W-1:0]      pc_mag_q;
	logic                     pc_neg_q;

	always_comb begin
		diff      = {last_q[SAMPLE_W-1], last_q} - {first_q[SAMPLE_W-1], first_q};
		dmag      = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
		first_mag = first_q[SAMPLE_W-1] ? (~first_q + 1'b1) : first_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			pc_mag_q <= dmag * PC_SCALE;
			pc_neg_q <= diff[SAMPLE_W] ^ first_q[SAMPLE_W-1];
		end
	end

	// shared divider and its operands
	logic [SUMW-1:0] sum_mag;
	logic [DVW-1:0]  dvd;
	logic [DSW-1:0]  dvs;
	logic [DVW-1:0]  quo;
	logic            div_busy;
	logic            div_done;

	always_comb begin
		sum_mag = sum_q[SUMW-1] ? (~sum_q + 1'b1) : sum_q;
		case (cmd.div_sel)
			DIV_MEAN: begin
				dvd = DVW'(sum_mag) + DVW'(n_q >> 1);
				dvs = DSW'(n_q);
			end
			DIV_ESQ: begin
				dvd = DVW'(sqsum_q);
				dvs = DSW'(n_q);
			end
			DIV_PC: begin
				dvd = DVW'(pc_mag_q) + DVW'(first_mag >> 1);
				dvs = DSW'(first_mag);
			end
			default: begin
				dvd = '0;
				dvs = DSW'(1);
			end
		endcase
	end

	ses_div #(.QW(DVW), .DW(DSW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	// mean, second moment, variance
	logic signed [MEAN_W-1:0] mean_q;
	logic [SQW-1:0]           esq_q;
	logic [MEAN_W-1:0]        mean_mag;
	logic [MSQW-1:0]          msq_q;
	logic [SQW-1:0]           var_q;

	assign mean_mag = mean_q[MEAN_W-1] ? (~mean_q + 1'b1) : mean_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_mean) begin
			mean_q <= sum_q[SUMW-1] ? (~quo[MEAN_W-1:0] + 1'b1) : quo[MEAN_W-1:0];
		end
		if (cmd.cap_esq) begin
			esq_q <= quo[SQW-1:0];
		end
		if (cmd.msq) begin
			msq_q <= mean_mag * mean_mag;
		end
		if (cmd.var_en) begin
			var_q <= (esq_q > SQW'(msq_q)) ? esq_q - SQW'(msq_q) : '0;
		end
	end

	// square root of the variance
	logic [SQRT_OUT_W-1:0] root;
	logic                  sqrt_busy;
	logic                  sqrt_done;

	ses_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (SQRT_IN_W'(var_q)),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (root)
	);

	// saturated percent change
	logic signed [PC_W-1:0] pc_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_pc) begin
			if (pc_neg_q) begin
				pc_q <= (quo > DVW'(33'h080000000)) ? {1'b1, {(PC_W-1){1'b0}}}
					: (~quo[PC_W-1:0] + 1'b1);
			end else begin
				pc_q <= (quo > DVW'(32'h7FFFFFFF)) ? {1'b0, {(PC_W-1){1'b1}}}
					: quo[PC_W-1:0];
			end
		end
	end

	// set counter within the batch
	logic [SETS_W-1:0] set_q;
	logic [SETS_W:0]   spb_eff;
	logic [SETS_W:0]   set_next;
	logic              is_last;

	always_comb begin
		spb_eff  = (sets_q == '0) ? (SETS_W+1)'(1) : {1'b0, sets_q};
		set_next = {1'b0, set_q} + 1'b1;
		is_last  = set_next >= spb_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_q <= '0;
		end else if (cmd.load_out) begin
			set_q <= is_last ? '0 : set_next[SETS_W-1:0];
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mean_value     <= mean_q;
			std_deviation  <= (root > SQRT_OUT_W'(SD_MAX)) ? SD_MAX : root[SD_W-1:0];
			pct_change     <= (first_q == '0) ? '0 : pc_q;
			first_was_zero <= first_q == '0;
			set_index      <= set_q;
			last_set       <= is_last;
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	always_comb begin
		stat.close      = n_now >= len_eff;
		stat.div_done   = div_done;
		stat.div_busy   = div_busy;
		stat.sqrt_done  = sqrt_done;
		stat.sqrt_busy  = sqrt_busy;
		stat.out_free   = !out_valid_q || out_ready;
		stat.first_zero = first_q == '0;
	end
endmodule
`default_nettype wire

@@ hdl/ses_ctrl.sv @@
// controller: sequences accumulation and the per-set back end
`default_nettype none
module ses_ctrl import ses_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire ses_stat_t stat,
	output ses_cmd_t       cmd
);
	localparam logic [3:0] S_ACC    = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_MEAN   = 4'd2;
	localparam logic [3:0] S_ESQ    = 4'd3;
	localparam logic [3:0] S_MSQ    = 4'd4;
	localparam logic [3:0] S_VAR    = 4'd5;
	localparam logic [3:0] S_SQGO   = 4'd6;
	localparam logic [3:0] S_SQRT   = 4'd7;
	localparam logic [3:0] S_PC     = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_MEAN;
		in_ready    = state_q == S_ACC;
		case (state_q)
			S_ACC: begin
				cmd.acc = in_valid;
				if (in_valid && stat.close) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				cmd.prep      = 1'b1;
				cmd.div_start = 1'b1;
				cmd.div_sel   = DIV_MEAN;
				state_d       = S_MEAN;
			end
			S_MEAN: begin
				if (stat.div_done) begin
					cmd.cap_mean  = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_ESQ;
					state_d       = S_ESQ;
				end
			end
			S_ESQ: begin
				if (stat.div_done) begin
					cmd.cap_esq = 1'b1;
					state_d     = S_MSQ;
				end
			end
			S_MSQ: begin
				cmd.msq = 1'b1;
				state_d = S_VAR;
			end
			S_VAR: begin
				cmd.var_en = 1'b1;
				state_d    = S_SQGO;
			end
			S_SQGO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = S_SQRT;
			end
			S_SQRT: begin
				if (stat.sqrt_done) begin
					if (stat.first_zero) begin
						state_d = S_OUT;
					end else begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_PC;
						state_d       = S_PC;
					end
				end
			end
			S_PC: begin
				if (stat.div_done) begin
					cmd.cap_pc = 1'b1;
					state_d    = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

@@ hdl/set_statistics_engine_top.sv @@
// Set statistics engine: per-set mean, population standard deviation and
// percent change of signed Q15.8 samples. Inside a set a sample transfer is
// taken every cycle. After the sample that closes a set, input ready stays
// low while the back end runs: two divisions on the shared shift-subtract
// divider (DVW = 58 at the default MAX_ENTRIES), a square root, a third
// division for the percent change unless the first sample was zero, and
// the set-up steps between them; it also stays low until the output
// register is free. The result then sits in an output register, so the
// next set's samples are taken while it waits for its transfer.
`default_nettype none
module set_statistics_engine_top import ses_pkg::*; #(
	parameter int MAX_ENTRIES = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [SAMPLE_W-1:0]   sample,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic signed [MEAN_W-1:0]   mean_value,
	output logic [SD_W-1:0]            std_deviation,
	output logic signed [PC_W-1:0]     pct_change,
	output logic                       first_was_zero,
	output logic [SETS_W-1:0]          set_index,
	output logic                       last_set
);
	ses_cmd_t  cmd;
	ses_stat_t stat;

	// sequencing
	ses_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic
	ses_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample         (sample),
		.cmd            (cmd),
		.stat           (stat),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.mean_value     (mean_value),
		.std_deviation  (std_deviation),
		.pct_change     (pct_change),
		.first_was_zero (first_was_zero),
		.set_index      (set_index),
		.last_set       (last_set)
	);

	// checks
`include "set_statistics_engine_top_macros.svh"
	`SES_AST_IMP(a_idle_units_when_taking, in_ready, !stat.div_busy && !stat.sqrt_busy)
	`SES_AST_IMP(a_no_result_overwrite, cmd.load_out, !out_valid || out_ready)
	`SES_AST_NEXT(a_load_shows_result, cmd.load_out, out_valid)
	`SES_AST_IMP(a_zero_first_no_change, out_valid && first_was_zero, pct_change == '0)
endmodule
`default_nettype wire
